FILE: rtl/core/sensor_response_frame_parser_core_macros.svh
// assertion macros shared by the frame parser rtl
`ifndef SENSOR_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH
`define SENSOR_RESPONSE_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SRFP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srfp assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SRFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srfp assertion failed");

`endif

FILE: rtl/core/srfp_pkg.sv
`default_nettype none

package srfp_pkg;

   // input beat kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result beat kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // end-of-frame status codes
   localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
   localparam logic [1:0] STATUS_BAD_START = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR  = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_EXPECTED_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_START_WORD       = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS    = 2'd2;

   localparam int unsigned CSR_DATA_WIDTH = 32;

   // register reset values
   localparam logic [31:0] EXPECTED_ADDRESS_RESET = 32'hFFFF_FFFF;
   localparam logic [15:0] START_WORD_RESET       = 16'hEF01;
   localparam logic [15:0] TIMEOUT_TICKS_RESET    = 16'd1000;

   // length field counts type-independent overhead bytes beyond the payload
   localparam logic [15:0] LEN_OVERHEAD = 16'd3;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [7:0]  confirm_code;
      logic [7:0]  frame_type;
      logic [15:0] payload_count;
      logic        sum_ok;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/srfp_channels.sv
`default_nettype none

// input channel: received byte or time tick
interface srfp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// result channel: payload byte or end of frame
interface srfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [7:0]  confirm_code;
   logic [7:0]  frame_type;
   logic [15:0] payload_count;
   logic        sum_ok;

   modport source (output valid, output kind, output payload_byte, output status,
                   output confirm_code, output frame_type, output payload_count,
                   output sum_ok, input ready);
   modport sink   (input valid, input kind, input payload_byte, input status,
                   input confirm_code, input frame_type, input payload_count,
                   input sum_ok, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srfp_rsp_stage.sv
`default_nettype none

// result register: holds one beat until the sink takes it
module srfp_rsp_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire srfp_pkg::result_type load_data,
   output logic                      can_load,
   srfp_rsp_if.source                rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   srfp_pkg::result_type data_ff;

   // space when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.kind          = data_ff.kind;
   assign rsp.payload_byte  = data_ff.payload_byte;
   assign rsp.status        = data_ff.status;
   assign rsp.confirm_code  = data_ff.confirm_code;
   assign rsp.frame_type    = data_ff.frame_type;
   assign rsp.payload_count = data_ff.payload_count;
   assign rsp.sum_ok        = data_ff.sum_ok;

endmodule

`default_nettype wire

FILE: rtl/core/sensor_response_frame_parser_core.sv
// Response frame parser for a serial sensor link. Each req beat is one received byte
// or one elapsed time tick; the parser walks the big-endian frame (start code,
// address, type, length, confirm code, payload, checksum), emits one rsp beat per
// payload byte and one end beat per completed or aborted frame, with a 16-bit sum
// check. A beat is taken every cycle: the frame state updates on acceptance and the
// result lands in a one-deep output register in the next cycle. req.ready drops only
// while that register holds a beat that rsp does not take in the same cycle. The
// user must write configuration through the csr port while idle; nothing checks it.
`default_nettype none

`include "sensor_response_frame_parser_core_macros.svh"

module sensor_response_frame_parser_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   srfp_req_if.sink                                    req,
   srfp_rsp_if.source                                  rsp,
   input  wire logic                                   csr_write_enable,
   input  wire logic [1:0]                             csr_index,
   input  wire logic [srfp_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   // frame phase codes
   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_ADDR    = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_LEN     = 3'd3;
   localparam logic [2:0] PH_CONF    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_SUM     = 3'd6;

   // configuration registers
   logic [31:0] expected_address_ff;
   logic [15:0] start_word_ff;
   logic [15:0] timeout_ticks_ff;

   // frame state
   logic [2:0]  phase_ff,        phase_in;
   logic [31:0] field_shift_ff,  field_shift_in;
   logic [1:0]  byte_index_ff,   byte_index_in;
   logic [7:0]  held_type_ff,    held_type_in;
   logic [7:0]  held_confirm_ff, held_confirm_in;
   logic [15:0] bytes_left_ff,   bytes_left_in;
   logic [15:0] running_sum_ff,  running_sum_in;
   logic [15:0] wait_count_ff,   wait_count_in;

   logic                 accept;
   logic                 can_load;
   logic                 emit;
   logic                 clear_frame;
   srfp_pkg::result_type result;
   logic [15:0]          pair_word;
   logic [31:0]          addr_word;
   logic [15:0]          sum_plus_byte;
   logic [15:0]          left_minus_one;

   assign req.ready = can_load;
   assign accept    = req.valid && req.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_address_ff <= srfp_pkg::EXPECTED_ADDRESS_RESET;
         start_word_ff       <= srfp_pkg::START_WORD_RESET;
         timeout_ticks_ff    <= srfp_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            srfp_pkg::CSR_EXPECTED_ADDRESS: expected_address_ff <= csr_write_data[31:0];
            srfp_pkg::CSR_START_WORD:       start_word_ff       <= csr_write_data[15:0];
            srfp_pkg::CSR_TIMEOUT_TICKS:    timeout_ticks_ff    <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // byte assembly helpers
   assign pair_word      = {field_shift_ff[7:0], req.rx_byte};
   assign addr_word      = {field_shift_ff[23:0], req.rx_byte};
   assign sum_plus_byte  = running_sum_ff + {8'd0, req.rx_byte};
   assign left_minus_one = bytes_left_ff - 16'd1;

   // frame machine: one beat per cycle while req.ready is high
   always_comb begin
      phase_in        = phase_ff;
      field_shift_in  = field_shift_ff;
      byte_index_in   = byte_index_ff;
      held_type_in    = held_type_ff;
      held_confirm_in = held_confirm_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      wait_count_in   = wait_count_ff;
      emit            = 1'b0;
      clear_frame     = 1'b0;
      result          = '0;

      if (accept) begin
         if (req.op == srfp_pkg::OP_TICK) begin
            // ticks are ignored while hunting the first start byte
            if (!(phase_ff == PH_START && byte_index_ff == 2'd0)) begin
               if (wait_count_ff >= timeout_ticks_ff) begin
                  emit          = 1'b1;
                  clear_frame   = 1'b1;
                  result.kind   = srfp_pkg::KIND_END;
                  result.status = srfp_pkg::STATUS_TIMEOUT;
               end else begin
                  wait_count_in = wait_count_ff + 16'd1;
               end
            end
         end else begin
            wait_count_in = '0;
            unique case (phase_ff)
               PH_ADDR: begin
                  field_shift_in = addr_word;
                  if (byte_index_ff == 2'd3) begin
                     if (addr_word != expected_address_ff) begin
                        emit          = 1'b1;
                        clear_frame   = 1'b1;
                        result.kind   = srfp_pkg::KIND_END;
                        result.status = srfp_pkg::STATUS_BAD_ADDR;
                     end else begin
                        phase_in       = PH_TYPE;
                        field_shift_in = '0;
                        byte_index_in  = '0;
                     end
                  end else begin
                     byte_index_in = byte_index_ff + 2'd1;
                  end
               end
               PH_TYPE: begin
                  held_type_in   = req.rx_byte;
                  running_sum_in = {8'd0, req.rx_byte};
                  phase_in       = PH_LEN;
                  field_shift_in = '0;
                  byte_index_in  = '0;
               end
               PH_LEN: begin
                  running_sum_in = sum_plus_byte;
                  field_shift_in = {16'd0, pair_word};
                  if (byte_index_ff == 2'd1) begin
                     bytes_left_in  = pair_word - srfp_pkg::LEN_OVERHEAD;
                     field_shift_in = {pair_word - srfp_pkg::LEN_OVERHEAD, 16'd0};
                     byte_index_in  = '0;
                     phase_in       = PH_CONF;
                  end else begin
                     byte_index_in = 2'd1;
                  end
               end
               PH_CONF: begin
                  held_confirm_in = req.rx_byte;
                  running_sum_in  = sum_plus_byte;
                  phase_in        = (bytes_left_ff != 16'd0) ? PH_PAYLOAD : PH_SUM;
                  byte_index_in   = '0;
               end
               PH_PAYLOAD: begin
                  running_sum_in = sum_plus_byte;
                  bytes_left_in  = left_minus_one;
                  if (left_minus_one == 16'd0) begin
                     phase_in      = PH_SUM;
                     byte_index_in = '0;
                  end
                  emit                = 1'b1;
                  result.kind         = srfp_pkg::KIND_PAYLOAD;
                  result.payload_byte = req.rx_byte;
                  result.status       = srfp_pkg::STATUS_COMPLETE;
                  result.confirm_code = held_confirm_ff;
                  result.frame_type   = held_type_ff;
               end
               PH_SUM: begin
                  field_shift_in = {field_shift_ff[31:16], pair_word};
                  if (byte_index_ff == 2'd1) begin
                     emit                 = 1'b1;
                     clear_frame          = 1'b1;
                     result.kind          = srfp_pkg::KIND_END;
                     result.status        = srfp_pkg::STATUS_COMPLETE;
                     result.confirm_code  = held_confirm_ff;
                     result.frame_type    = held_type_ff;
                     result.payload_count = field_shift_ff[31:16];
                     result.sum_ok        = (pair_word == running_sum_ff);
                  end else begin
                     byte_index_in = 2'd1;
                  end
               end
               default: begin
                  // start code hunt, also any unused phase code
                  phase_in       = PH_START;
                  field_shift_in = {16'd0, pair_word};
                  if (byte_index_ff != 2'd0) begin
                     if (pair_word != start_word_ff) begin
                        emit          = 1'b1;
                        clear_frame   = 1'b1;
                        result.kind   = srfp_pkg::KIND_END;
                        result.status = srfp_pkg::STATUS_BAD_START;
                     end else begin
                        phase_in       = PH_ADDR;
                        field_shift_in = '0;
                        byte_index_in  = '0;
                     end
                  end else begin
                     byte_index_in = 2'd1;
                  end
               end
            endcase
         end
      end

      // end of frame, good or bad: restart the hunt
      if (clear_frame) begin
         phase_in        = PH_START;
         field_shift_in  = '0;
         byte_index_in   = '0;
         held_type_in    = '0;
         held_confirm_in = '0;
         bytes_left_in   = '0;
         running_sum_in  = '0;
         wait_count_in   = '0;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         field_shift_ff  <= '0;
         byte_index_ff   <= '0;
         held_type_ff    <= '0;
         held_confirm_ff <= '0;
         bytes_left_ff   <= '0;
         running_sum_ff  <= '0;
         wait_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         field_shift_ff  <= field_shift_in;
         byte_index_ff   <= byte_index_in;
         held_type_ff    <= held_type_in;
         held_confirm_ff <= held_confirm_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
         wait_count_ff   <= wait_count_in;
      end
   end

   // output register
   srfp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .can_load  (can_load),
      .rsp       (rsp)
   );

   // checks
   `SRFP_ASSERT_NOW(a_stall_blocks_input, rsp.valid && !rsp.ready, !req.ready)
   `SRFP_ASSERT_NOW(a_payload_phase_has_bytes, phase_ff == PH_PAYLOAD, bytes_left_ff != 16'd0)
   `SRFP_ASSERT_NEXT(a_end_restarts_hunt, emit && result.kind == srfp_pkg::KIND_END, phase_ff == PH_START && byte_index_ff == 2'd0 && wait_count_ff == 16'd0)
   `SRFP_ASSERT_NEXT(a_emit_shows_result, emit, rsp.valid && rsp.kind == $past(result.kind))

endmodule

`default_nettype wire
